@@ hw/rtl/nsbc_pkg.sv @@
`default_nettype none
package nsbc_pkg;

  localparam int MaxRoundsDefault = 12;
  localparam int BlockW = 64;
  localparam int RoundW = 4;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegKey = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRounds = 1'b1;
  localparam logic CmdEnc = 1'b0;
  localparam logic CmdDec = 1'b1;

  typedef logic [BlockW-1:0] blk_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h7;
      4'h1: y = 4'h4;
      4'h2: y = 4'hA;
      4'h3: y = 4'h9;
      4'h4: y = 4'h1;
      4'h5: y = 4'hF;
      4'h6: y = 4'hB;
      4'h7: y = 4'h0;
      4'h8: y = 4'hC;
      4'h9: y = 4'h3;
      4'hA: y = 4'h2;
      4'hB: y = 4'h6;
      4'hC: y = 4'h8;
      4'hD: y = 4'hE;
      4'hE: y = 4'hD;
      default: y = 4'h5;
    endcase
    return y;
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return {sbox(b[7:4]), sbox(b[3:0])};
  endfunction

  function automatic logic [7:0] dbl(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  // Byte j of a block, byte 0 most significant.
  function automatic logic [7:0] byte_of(input blk_t w, input int j);
    return w[(BlockW-8-8*j) +: 8];
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, t;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    t = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ t ^ dbl(a0 ^ a1), a1 ^ t ^ dbl(a1 ^ a2),
            a2 ^ t ^ dbl(a2 ^ a3), a3 ^ t ^ dbl(a3 ^ a0)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] u, v;
    u = dbl(dbl(c[31:24] ^ c[15:8]));
    v = dbl(dbl(c[23:16] ^ c[7:0]));
    return mix_col(c ^ {u, v, u, v});
  endfunction

  function automatic blk_t next_key(input blk_t k, input logic [7:0] rnd);
    return {byte_of(k, 5), byte_of(k, 6), byte_of(k, 7) ^ rnd, byte_of(k, 4),
            byte_of(k, 1) ^ byte_of(k, 5),
            sub_byte(byte_of(k, 2) ^ byte_of(k, 6)),
            sub_byte(byte_of(k, 3) ^ byte_of(k, 7)),
            byte_of(k, 0) ^ byte_of(k, 4)};
  endfunction

  function automatic blk_t enc_round(input blk_t s, input blk_t rk);
    blk_t t, r;
    for (int j = 0; j < 8; j++) begin
      t[(BlockW-8-8*j) +: 8] = sub_byte(byte_of(s ^ rk, j));
    end
    r = {t[47:0], t[63:48]};
    return {mix_col(r[63:32]), mix_col(r[31:0])};
  endfunction

  function automatic blk_t dec_round(input blk_t s, input blk_t rk);
    blk_t m, t, o;
    m = {inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
    t = {m[15:0], m[63:16]};
    for (int j = 0; j < 8; j++) begin
      o[(BlockW-8-8*j) +: 8] = sub_byte(byte_of(t, j));
    end
    return o ^ rk;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nibble_spn_block_cipher_64_unit.sv @@
// An input beat passes the entry stage, the round cells and the output register.
// One beat per cycle while in_tready is high; the round cells move in lockstep.
// The round keys are expanded by a key cell chain from the key register; after
// reset and after every configuration write the input holds off (in_tready low)
// until the chain carries the new round keys.
// Reset (synchronous, rst_n low) clears valids, key to 0 and rounds to 12.
`default_nettype none
module nibble_spn_block_cipher_64_unit #(
  parameter int MAX_ROUNDS = nsbc_pkg::MaxRoundsDefault
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // block_in [63:0]
  input  wire         in_tuser,   // cmd
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [63:0] out_tdata,  // block_out [63:0]
  input  wire         cfg_we,
  input  wire  [nsbc_pkg::CfgIdxW-1:0] cfg_idx,
  input  wire  [63:0] cfg_wdata
);
  import nsbc_pkg::*;

  localparam int SettleW = $clog2(MAX_ROUNDS + 1);

  blk_t key_r;
  logic [RoundW-1:0] rounds_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      rounds_r <= RoundW'(12);
    end else if (cfg_we) begin
      if (cfg_idx == RegKey) key_r <= cfg_wdata;
      if (cfg_idx == RegRounds) rounds_r <= cfg_wdata[RoundW-1:0];
    end
  end

  // Counts down while the key cell chain is still carrying stale round keys.
  logic [SettleW-1:0] settle_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SettleW'(MAX_ROUNDS);
    end else if (cfg_we) begin
      settle_r <= SettleW'(MAX_ROUNDS);
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  // Round key chain: rk[i] is round key i.
  blk_t rk [MAX_ROUNDS+1];
  assign rk[0] = key_r;
  for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_key
    nsbc_key_cell #(.Idx(g)) u_key (.clk(clk), .k_in(rk[g-1]), .k_out(rk[g]));
  end

  // Saturated round count and whitening key.
  logic [RoundW-1:0] r_eff;
  assign r_eff = (32'(rounds_r) > MAX_ROUNDS) ? RoundW'(MAX_ROUNDS) : rounds_r;
  blk_t rk_last;
  always_comb begin
    rk_last = rk[0];
    for (int i = 1; i <= MAX_ROUNDS; i++) begin
      if (32'(r_eff) == i) rk_last = rk[i];
    end
  end

  // The chain stalls as a whole when the output register is full and not taken.
  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en && (settle_r == '0);

  // Entry stage: decrypt items take the whitening key first.
  logic v0_r, cmd0_r;
  logic [RoundW-1:0] r0_r;
  blk_t s0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid && in_tready;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd0_r <= in_tuser;
      r0_r <= r_eff;
      s0_r <= (in_tuser == CmdDec) ? (in_tdata ^ rk_last) : in_tdata;
    end
  end

  logic v [MAX_ROUNDS+1];
  logic c [MAX_ROUNDS+1];
  logic [RoundW-1:0] rr [MAX_ROUNDS+1];
  blk_t s [MAX_ROUNDS+1];
  assign v[0] = v0_r;
  assign c[0] = cmd0_r;
  assign rr[0] = r0_r;
  assign s[0] = s0_r;

  for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_round
    blk_t rkd;
    // Decrypt cell g undoes round r-g+1, using key r-g.
    always_comb begin
      rkd = rk[0];
      for (int i = 0; i < MAX_ROUNDS; i++) begin
        if (32'(rr[g-1]) - g == i) rkd = rk[i];
      end
    end
    nsbc_round_cell #(.Idx(g)) u_round (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(v[g-1]), .cmd_in(c[g-1]), .r_in(rr[g-1]), .s_in(s[g-1]),
      .rk_enc(rk[g-1]), .rk_dec(rkd),
      .v_out(v[g]), .cmd_out(c[g]), .r_out(rr[g]), .s_out(s[g])
    );
  end

  // Output register: encrypt items take the whitening key here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (en) begin
      out_tvalid <= v[MAX_ROUNDS];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata <= (c[MAX_ROUNDS] == CmdEnc) ? (s[MAX_ROUNDS] ^ rk_last) : s[MAX_ROUNDS];
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/nsbc_key_cell.sv @@
`default_nettype none
// Key schedule cell: round key i from round key i-1, registered.
module nsbc_key_cell #(
  parameter int Idx = 1
) (
  input  wire              clk,
  input  wire nsbc_pkg::blk_t k_in,
  output nsbc_pkg::blk_t   k_out
);
  import nsbc_pkg::*;
  blk_t k_r;
  always_ff @(posedge clk) begin
    k_r <= next_key(k_in, 8'(Idx));
  end
  assign k_out = k_r;
endmodule
`default_nettype wire

@@ hw/rtl/nsbc_round_cell.sv @@
`default_nettype none
// One round cell (pass-through when r < Idx). Encrypt items use forward key
// Idx-1; decrypt items at cell Idx undo round r-Idx+1, keyed by the top level.
module nsbc_round_cell #(
  parameter int Idx = 1
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  en,
  input  wire                  v_in,
  input  wire                  cmd_in,
  input  wire [nsbc_pkg::RoundW-1:0] r_in,
  input  wire nsbc_pkg::blk_t  s_in,
  input  wire nsbc_pkg::blk_t  rk_enc,
  input  wire nsbc_pkg::blk_t  rk_dec,
  output logic                 v_out,
  output logic                 cmd_out,
  output logic [nsbc_pkg::RoundW-1:0] r_out,
  output nsbc_pkg::blk_t       s_out
);
  import nsbc_pkg::*;
  logic v_r, cmd_r;
  logic [RoundW-1:0] r_r;
  blk_t s_r, s_nxt;
  logic act;
  assign act = (32'(r_in) >= Idx);
  always_comb begin
    if (!act) begin
      s_nxt = s_in;
    end else if (cmd_in == CmdDec) begin
      s_nxt = dec_round(s_in, rk_dec);
    end else begin
      s_nxt = enc_round(s_in, rk_enc);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r <= cmd_in;
      r_r <= r_in;
      s_r <= s_nxt;
    end
  end
  assign v_out = v_r;
  assign cmd_out = cmd_r;
  assign r_out = r_r;
  assign s_out = s_r;
endmodule
`default_nettype wire

@@ hw/rtl/nsbc_checker.sv @@
`default_nettype none
module nsbc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat dropped while stalled");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid |-> !$isunknown(in_tready))
    else $error("input ready unknown while a beat is offered");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while chain stalled");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule
bind nibble_spn_block_cipher_64_unit nsbc_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire
